// ===== rtl/core/disc_ring_intensity_ratio_assert.svh =====
// Assertion macros for the disc ring intensity ratio block.
`ifndef DISC_RING_INTENSITY_RATIO_ASSERT_SVH
`define DISC_RING_INTENSITY_RATIO_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define DRIR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("drir: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define DRIR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("drir: next-cycle check failed");

`endif

// ===== rtl/core/drir_pkg.sv =====
package drir_pkg;

    localparam int COORD_BITS = 12;
    localparam int COUNT_BITS = 24;
    localparam int FRAC_BITS  = 4;

    localparam int CFG_W    = 16;
    localparam int MODE_W   = 2;
    localparam int PIX_W    = 8;
    localparam int SUM_W    = 32;
    localparam int SQ_W     = 40;
    localparam int METRIC_W = 32;
    localparam int STATUS_W = 2;
    localparam int QFRAC    = 16;

    localparam int POS_W  = COORD_BITS + FRAC_BITS;
    localparam int DIFF_W = (POS_W > CFG_W) ? POS_W : CFG_W;
    localparam int SQR_W  = 2 * DIFF_W;
    localparam int D2_W   = SQR_W + 1;
    localparam int R2_W   = 2 * CFG_W;
    localparam int CMP_W  = (D2_W > R2_W + 2) ? D2_W : R2_W + 2;

    localparam int SQRT_IN_W  = SQ_W + QFRAC;
    localparam int ROOT_W     = SQRT_IN_W / 2;
    localparam int SQRT_REM_W = ROOT_W + 3;
    localparam int SQRT_CNT_W = $clog2(ROOT_W + 1);

    localparam int TOP_W      = (SUM_W > ROOT_W) ? SUM_W : ROOT_W;
    localparam int PROD_W     = TOP_W + COUNT_BITS;
    localparam int DIV_STEPS  = METRIC_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_CENTER_X   = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CENTER_Y   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_RADIUS     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_RATIO_MODE = 2'd3;

    localparam logic [1:0] REGION_NONE = 2'd0;
    localparam logic [1:0] REGION_DISC = 2'd1;
    localparam logic [1:0] REGION_RING = 2'd2;

    localparam logic [MODE_W-1:0] MODE_MEAN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RSS  = 2'd1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_MODE  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_ZERO_DEN = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [METRIC_W-1:0]   Q_MAX     = '1;

    typedef struct packed {
        logic [CFG_W-1:0]  center_x;
        logic [CFG_W-1:0]  center_y;
        logic [R2_W-1:0]   r2;
        logic [MODE_W-1:0] mode;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       region;
        logic [PIX_W-1:0] intensity;
        logic             last;
    } pix_entry_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] disc_count;
        logic [COUNT_BITS-1:0] ring_count;
        logic [SUM_W-1:0]      disc_sum;
        logic [SUM_W-1:0]      ring_sum;
        logic [SQ_W-1:0]       disc_sq;
        logic [SQ_W-1:0]       ring_sq;
    } acc_t;

endpackage

// ===== rtl/core/drir_if.sv =====
interface drir_pix_if import drir_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pix_x;
    logic [COORD_BITS-1:0] pix_y;
    logic [PIX_W-1:0]      intensity;
    logic                  last_pixel;

    modport source (output valid, pix_x, pix_y, intensity, last_pixel, input ready);
    modport sink (input valid, pix_x, pix_y, intensity, last_pixel, output ready);
endinterface

interface drir_res_if import drir_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [METRIC_W-1:0] metric;
    logic [STATUS_W-1:0] status;

    modport source (output valid, metric, status, input ready);
    modport sink (input valid, metric, status, output ready);
endinterface

// ===== rtl/core/disc_ring_intensity_ratio.sv =====
// Disc to ring intensity ratio over one measurement of pixels.
// The pix channel carries one word per pixel: column, row, grey level and a
// last-pixel mark. Pixels are classified by squared distance from the circle
// set in the registers, then accumulated for the disc and the ring.
// One pixel is accepted per cycle unless back-pressure stalls the pipeline.
// Classification runs through the s1, s2 and s3 pipeline registers, and a
// four-word queue feeds the accumulator. The last pixel of a measurement
// starts the result sequence, which uses the 32-step quotient divider and, in
// root-sum-square mode, the two 28-step square root units. During that
// sequence the accumulator takes no words, so pix.ready drops once the queue
// and the pipeline hold seven pixels.
// The res channel carries one word per measurement: the Q16.16 metric and a
// status code. The result waits in an output register; a stalled receiver
// holds it there, and new pixels keep flowing until a second result is ready.
// Registers are written through the APB port; write them only while the block is idle (not enforced by the block).
// Reset clears the registers, the accumulators, the queue and all valid flags.
module disc_ring_intensity_ratio import drir_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    drir_pix_if.sink           pix,
    drir_res_if.source         res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

`include "disc_ring_intensity_ratio_assert.svh"

    logic [CFG_W-1:0]     center_x_reg;
    logic [CFG_W-1:0]     center_y_reg;
    logic [CFG_W-1:0]     radius_reg;
    logic [MODE_W-1:0]    mode_reg;
    logic [R2_W-1:0]      r2_reg;

    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    cfg_t                 cfg;

    logic                 fe_valid;
    logic                 fe_ready;
    pix_entry_t           fe_word;
    logic                 bk_valid;
    logic                 bk_ready;
    pix_entry_t           bk_word;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    assign cfg.center_x = center_x_reg;
    assign cfg.center_y = center_y_reg;
    assign cfg.r2       = r2_reg;
    assign cfg.mode     = mode_reg;

    always_comb
    begin
        unique case (reg_idx)
            REG_CENTER_X:   prdata = PDATA_W'(center_x_reg);
            REG_CENTER_Y:   prdata = PDATA_W'(center_y_reg);
            REG_RADIUS:     prdata = PDATA_W'(radius_reg);
            REG_RATIO_MODE: prdata = PDATA_W'(mode_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
            mode_reg     <= '0;
            r2_reg       <= '0;
        end
        else
        begin
            r2_reg <= R2_W'(radius_reg) * R2_W'(radius_reg);
            if (cfg_wr)
            begin
                unique case (reg_idx)
                    REG_CENTER_X:   center_x_reg <= pwdata[CFG_W-1:0];
                    REG_CENTER_Y:   center_y_reg <= pwdata[CFG_W-1:0];
                    REG_RADIUS:     radius_reg   <= pwdata[CFG_W-1:0];
                    REG_RATIO_MODE: mode_reg     <= pwdata[MODE_W-1:0];
                    default:        mode_reg     <= mode_reg;
                endcase
            end
        end
    end

    drir_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix       (pix),
        .cfg       (cfg),
        .ent_valid (fe_valid),
        .ent_ready (fe_ready),
        .ent       (fe_word)
    );

    drir_fifo u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (fe_word),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_word)
    );

    drir_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .ent_valid (bk_valid),
        .ent_ready (bk_ready),
        .ent       (bk_word),
        .res       (res)
    );

    `DRIR_ASSERT_IMP(a_zero_den_saturates, res.valid && res.status == STATUS_ZERO_DEN, res.metric == Q_MAX)
    `DRIR_ASSERT_IMP(a_flagged_metric_zero, res.valid && (res.status == STATUS_EMPTY || res.status == STATUS_NO_MODE), res.metric == '0)
    `DRIR_ASSERT_NEXT(a_last_halts_accumulator, bk_valid && bk_ready && bk_word.last, !bk_ready)

endmodule

// ===== rtl/core/drir_front.sv =====
module drir_front import drir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    drir_pix_if.sink   pix,
    input  cfg_t       cfg,
    output logic       ent_valid,
    input  logic       ent_ready,
    output pix_entry_t ent
);

    logic                s1_valid_reg;
    logic [DIFF_W-1:0]   s1_dx_reg;
    logic [DIFF_W-1:0]   s1_dy_reg;
    logic [PIX_W-1:0]    s1_int_reg;
    logic                s1_last_reg;

    logic                s2_valid_reg;
    logic [SQR_W-1:0]    s2_dx2_reg;
    logic [SQR_W-1:0]    s2_dy2_reg;
    logic [PIX_W-1:0]    s2_int_reg;
    logic                s2_last_reg;

    logic                s3_valid_reg;
    pix_entry_t          s3_ent_reg;

    logic                s1_adv;
    logic                s2_adv;
    logic                s3_adv;
    logic [DIFF_W-1:0]   px;
    logic [DIFF_W-1:0]   py;
    logic [DIFF_W-1:0]   cx;
    logic [DIFF_W-1:0]   cy;
    logic [DIFF_W-1:0]   dx;
    logic [DIFF_W-1:0]   dy;
    logic [CMP_W-1:0]    d2;
    logic [CMP_W-1:0]    r2;
    logic [CMP_W-1:0]    r2x4;
    logic [1:0]          region;

    assign s3_adv    = !s3_valid_reg || ent_ready;
    assign s2_adv    = !s2_valid_reg || s3_adv;
    assign s1_adv    = !s1_valid_reg || s2_adv;
    assign pix.ready = s1_adv;
    assign ent_valid = s3_valid_reg;
    assign ent       = s3_ent_reg;

    always_comb
    begin
        px = DIFF_W'(pix.pix_x) << FRAC_BITS;
        py = DIFF_W'(pix.pix_y) << FRAC_BITS;
        cx = DIFF_W'(cfg.center_x);
        cy = DIFF_W'(cfg.center_y);
        dx = (px >= cx) ? px - cx : cx - px;
        dy = (py >= cy) ? py - cy : cy - py;
    end

    always_comb
    begin
        d2   = CMP_W'(s2_dx2_reg) + CMP_W'(s2_dy2_reg);
        r2   = CMP_W'(cfg.r2);
        r2x4 = r2 << 2;
        if (d2 < r2)
        begin
            region = REGION_DISC;
        end
        else if (d2 < r2x4)
        begin
            region = REGION_RING;
        end
        else
        begin
            region = REGION_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                s1_valid_reg <= pix.valid;
            end
            if (s2_adv)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_adv)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s1_dx_reg   <= dx;
            s1_dy_reg   <= dy;
            s1_int_reg  <= pix.intensity;
            s1_last_reg <= pix.last_pixel;
        end
        if (s2_adv)
        begin
            s2_dx2_reg  <= SQR_W'(s1_dx_reg) * SQR_W'(s1_dx_reg);
            s2_dy2_reg  <= SQR_W'(s1_dy_reg) * SQR_W'(s1_dy_reg);
            s2_int_reg  <= s1_int_reg;
            s2_last_reg <= s1_last_reg;
        end
        if (s3_adv)
        begin
            s3_ent_reg.region    <= region;
            s3_ent_reg.intensity <= s2_int_reg;
            s3_ent_reg.last      <= s2_last_reg;
        end
    end

endmodule

// ===== rtl/core/drir_fifo.sv =====
module drir_fifo import drir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  pix_entry_t push_data,
    output logic       pop_valid,
    input  logic       pop_ready,
    output pix_entry_t pop_data
);

    pix_entry_t         mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW:0]   count_reg;
    logic               do_push;
    logic               do_pop;

    assign push_ready = count_reg != (FIFO_AW + 1)'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/drir_isqrt.sv =====
module drir_isqrt import drir_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [SQRT_IN_W-1:0] radicand,
    output logic                 busy,
    output logic [ROOT_W-1:0]    root
);

    logic                  busy_reg;
    logic [SQRT_CNT_W-1:0] cnt_reg;
    logic [SQRT_IN_W-1:0]  rad_reg;
    logic [SQRT_REM_W-1:0] rem_reg;
    logic [ROOT_W-1:0]     root_reg;

    logic [SQRT_REM_W-1:0] rem_sh;
    logic [SQRT_REM_W-1:0] trial;
    logic                  fits;

    assign busy = busy_reg;
    assign root = root_reg;

    always_comb
    begin
        rem_sh = {rem_reg[SQRT_REM_W-3:0], rad_reg[SQRT_IN_W-1 -: 2]};
        trial  = SQRT_REM_W'({root_reg, 2'b01});
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= SQRT_CNT_W'(ROOT_W);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == SQRT_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= fits ? rem_sh - trial : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

endmodule

// ===== rtl/core/drir_back.sv =====
module drir_back import drir_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       ent_valid,
    output logic       ent_ready,
    input  pix_entry_t ent,
    drir_res_if.source res
);

    localparam logic [3:0] ST_ACC       = 4'd0;
    localparam logic [3:0] ST_CHECK     = 4'd1;
    localparam logic [3:0] ST_SQRT      = 4'd2;
    localparam logic [3:0] ST_SQRT_WAIT = 4'd3;
    localparam logic [3:0] ST_MUL_N     = 4'd4;
    localparam logic [3:0] ST_MUL_D     = 4'd5;
    localparam logic [3:0] ST_DIV_CHK   = 4'd6;
    localparam logic [3:0] ST_DIV       = 4'd7;
    localparam logic [3:0] ST_DONE      = 4'd8;

    logic [3:0]           state_reg, state_next;
    acc_t                 acc_reg, acc_next;
    acc_t                 snap_reg, snap_next;
    logic [TOP_W-1:0]     top_reg, top_next;
    logic [TOP_W-1:0]     bot_reg, bot_next;
    logic [PROD_W-1:0]    num_reg, num_next;
    logic [PROD_W-1:0]    den_reg, den_next;
    logic [PROD_W-1:0]    rem_reg, rem_next;
    logic [METRIC_W-1:0]  qsh_reg, qsh_next;
    logic [METRIC_W-1:0]  quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [METRIC_W-1:0]  rmetric_reg, rmetric_next;
    logic [STATUS_W-1:0]  rstatus_reg, rstatus_next;
    logic                 out_valid_reg;
    logic [METRIC_W-1:0]  out_metric_reg;
    logic [STATUS_W-1:0]  out_status_reg;

    acc_t                 acc_upd;
    logic [2*PIX_W-1:0]   vsq;
    logic                 sqrt_start;
    logic                 busy_d;
    logic                 busy_r;
    logic [ROOT_W-1:0]    root_d;
    logic [ROOT_W-1:0]    root_r;
    logic [TOP_W-1:0]     mul_a;
    logic [COUNT_BITS-1:0] mul_b;
    logic [PROD_W-1:0]    mul_p;
    logic [PROD_W-1:0]    num_hi;
    logic [PROD_W:0]      rem_sh;
    logic                 rem_ge;
    logic [PROD_W:0]      rem_diff;
    logic                 out_free;

    function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] a, logic [PIX_W-1:0] v);
        logic [SUM_W:0] s;
        s = (SUM_W + 1)'(a) + (SUM_W + 1)'(v);
        return s[SUM_W] ? '1 : s[SUM_W-1:0];
    endfunction

    function automatic logic [SQ_W-1:0] sat_sq(logic [SQ_W-1:0] a, logic [2*PIX_W-1:0] v);
        logic [SQ_W:0] s;
        s = (SQ_W + 1)'(a) + (SQ_W + 1)'(v);
        return s[SQ_W] ? '1 : s[SQ_W-1:0];
    endfunction

    drir_isqrt u_sqrt_disc
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({snap_reg.disc_sq, QFRAC'(0)}),
        .busy     (busy_d),
        .root     (root_d)
    );

    drir_isqrt u_sqrt_ring
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand ({snap_reg.ring_sq, QFRAC'(0)}),
        .busy     (busy_r),
        .root     (root_r)
    );

    assign ent_ready  = state_reg == ST_ACC;
    assign out_free   = !out_valid_reg || res.ready;
    assign res.valid  = out_valid_reg;
    assign res.metric = out_metric_reg;
    assign res.status = out_status_reg;

    always_comb
    begin
        vsq     = (2 * PIX_W)'(ent.intensity) * (2 * PIX_W)'(ent.intensity);
        acc_upd = acc_reg;
        case (ent.region)
            REGION_DISC:
            begin
                if (acc_reg.disc_count != COUNT_MAX)
                begin
                    acc_upd.disc_count = acc_reg.disc_count + 1'b1;
                    acc_upd.disc_sum   = sat_sum(acc_reg.disc_sum, ent.intensity);
                    acc_upd.disc_sq    = sat_sq(acc_reg.disc_sq, vsq);
                end
            end
            REGION_RING:
            begin
                if (acc_reg.ring_count != COUNT_MAX)
                begin
                    acc_upd.ring_count = acc_reg.ring_count + 1'b1;
                    acc_upd.ring_sum   = sat_sum(acc_reg.ring_sum, ent.intensity);
                    acc_upd.ring_sq    = sat_sq(acc_reg.ring_sq, vsq);
                end
            end
            default:
            begin
                acc_upd = acc_reg;
            end
        endcase
    end

    always_comb
    begin
        mul_a    = (state_reg == ST_MUL_N) ? top_reg : bot_reg;
        mul_b    = (state_reg == ST_MUL_N) ? snap_reg.ring_count : snap_reg.disc_count;
        mul_p    = PROD_W'(mul_a) * PROD_W'(mul_b);
        num_hi   = num_reg >> QFRAC;
        rem_sh   = {rem_reg, qsh_reg[METRIC_W-1]};
        rem_ge   = rem_sh >= {1'b0, den_reg};
        rem_diff = rem_sh - {1'b0, den_reg};
    end

    always_comb
    begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        snap_next    = snap_reg;
        top_next     = top_reg;
        bot_next     = bot_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        qsh_next     = qsh_reg;
        quo_next     = quo_reg;
        cnt_next     = cnt_reg;
        rmetric_next = rmetric_reg;
        rstatus_next = rstatus_reg;
        sqrt_start   = 1'b0;
        unique case (state_reg)
            ST_ACC:
            begin
                if (ent_valid)
                begin
                    if (ent.last)
                    begin
                        acc_next   = '0;
                        snap_next  = acc_upd;
                        state_next = ST_CHECK;
                    end
                    else
                    begin
                        acc_next = acc_upd;
                    end
                end
            end
            ST_CHECK:
            begin
                if (snap_reg.disc_count == '0 || snap_reg.ring_count == '0)
                begin
                    rmetric_next = '0;
                    rstatus_next = STATUS_EMPTY;
                    state_next   = ST_DONE;
                end
                else if (cfg.mode == MODE_MEAN)
                begin
                    top_next   = TOP_W'(snap_reg.disc_sum);
                    bot_next   = TOP_W'(snap_reg.ring_sum);
                    state_next = ST_MUL_N;
                end
                else if (cfg.mode == MODE_RSS)
                begin
                    state_next = ST_SQRT;
                end
                else
                begin
                    rmetric_next = '0;
                    rstatus_next = STATUS_NO_MODE;
                    state_next   = ST_DONE;
                end
            end
            ST_SQRT:
            begin
                sqrt_start = 1'b1;
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT:
            begin
                if (!busy_d && !busy_r)
                begin
                    top_next   = TOP_W'(root_d);
                    bot_next   = TOP_W'(root_r);
                    state_next = ST_MUL_N;
                end
            end
            ST_MUL_N:
            begin
                if (bot_reg == '0)
                begin
                    rmetric_next = Q_MAX;
                    rstatus_next = STATUS_ZERO_DEN;
                    state_next   = ST_DONE;
                end
                else
                begin
                    num_next   = mul_p;
                    state_next = ST_MUL_D;
                end
            end
            ST_MUL_D:
            begin
                den_next   = mul_p;
                state_next = ST_DIV_CHK;
            end
            ST_DIV_CHK:
            begin
                if (num_hi >= den_reg)
                begin
                    rmetric_next = Q_MAX;
                    rstatus_next = STATUS_OK;
                    state_next   = ST_DONE;
                end
                else
                begin
                    rem_next   = num_hi;
                    qsh_next   = METRIC_W'(num_reg[QFRAC-1:0]) << (METRIC_W - QFRAC);
                    quo_next   = '0;
                    cnt_next   = DIV_CNT_W'(DIV_STEPS);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = rem_ge ? rem_diff[PROD_W-1:0] : rem_sh[PROD_W-1:0];
                qsh_next = qsh_reg << 1;
                quo_next = {quo_reg[METRIC_W-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    rmetric_next = {quo_reg[METRIC_W-2:0], rem_ge};
                    rstatus_next = STATUS_OK;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_ACC;
                end
            end
            default:
            begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        snap_reg    <= snap_next;
        top_reg     <= top_next;
        bot_reg     <= bot_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        rem_reg     <= rem_next;
        qsh_reg     <= qsh_next;
        quo_reg     <= quo_next;
        cnt_reg     <= cnt_next;
        rmetric_reg <= rmetric_next;
        rstatus_reg <= rstatus_next;
        if (state_reg == ST_DONE && out_free)
        begin
            out_metric_reg <= rmetric_reg;
            out_status_reg <= rstatus_reg;
        end
    end

endmodule
